// ===== rtl/waveform_nco_generator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the NCO block
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_NCO_GENERATOR_MACROS_SVH
`define WAVEFORM_NCO_GENERATOR_MACROS_SVH

// Check a property at every rising edge outside reset
`define WNG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define WNG_ASSERT_NEXT(name, pre, post, msg) \
  `WNG_ASSERT(name, (pre) |=> (post), msg)

`endif

// ===== rtl/wng_pkg.sv =====
// ----------------------------------------------------------------------------
// wng_pkg
// Widths, register indexes, wave codes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wng_pkg;

  // Phase accumulator and table sizing
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int STEP_W          = 32;
  localparam int FRAC_W          = 32;
  localparam int SUM_W           = ((PHASE_BITS > STEP_W) ? PHASE_BITS : STEP_W) + 1;
  localparam int TAB_N           = 1 << SINE_TABLE_BITS;
  localparam int ROM_ADDR_W      = SINE_TABLE_BITS + 1;

  // Data widths
  localparam int SINE_W     = 16;
  localparam int WAVE_W     = 17;
  localparam int AMP_W      = 16;
  localparam int PROD_W     = WAVE_W + AMP_W + 1;
  localparam int SCALE_SHIFT = 12;
  localparam int SAMPLE_W   = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Fixed-point constants
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(4096);
  localparam logic signed [WAVE_W-1:0] WAVE_POS_ONE = WAVE_W'(32768);
  localparam logic signed [WAVE_W-1:0] WAVE_NEG_ONE = -WAVE_W'(32768);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAWTOOTH = 2'd3
  } wave_t;

  typedef struct packed {
    wave_t             wave_type;
    logic [STEP_W-1:0] phase_step;
    logic [AMP_W-1:0]  amplitude;
  } cfg_t;

  typedef logic [SINE_W-1:0] sine_rom_t [0:TAB_N];

  // One table entry: Taylor series of sin(pi/2 * i / TAB_N) in Q30, rounded to Q15
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x    = (64'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 210;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 272;
    sum  = sum + term;
    sum  = (sum + 64'd16384) >> 15;
    return sum[SINE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned i = 0; i < TAB_N; i++) begin
      rom[i] = sine_entry(i);
    end
    rom[TAB_N] = SINE_W'(32768);
    return rom;
  endfunction

  // Quarter-wave table, TAB_N + 1 entries, evaluated at elaboration
  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ===== rtl/wng_cfg.sv =====
// ----------------------------------------------------------------------------
// wng_cfg
// Configuration register file: wave type, phase step and amplitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wng_cfg import wng_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Always able to take a word
  assign cfg_ready = 1'b1;

  // Write the addressed register, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_type  <= WAVE_SINE;
      cfg.phase_step <= '0;
      cfg.amplitude  <= AMP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WAVE_TYPE:  cfg.wave_type  <= wave_t'(cfg_data[1:0]);
        REG_PHASE_STEP: cfg.phase_step <= cfg_data[STEP_W-1:0];
        REG_AMPLITUDE:  cfg.amplitude  <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wng_phase.sv =====
// ----------------------------------------------------------------------------
// wng_phase
// Phase accumulator and first pipeline stage holding the phase fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "waveform_nco_generator_macros.svh"

module wng_phase import wng_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              tick_valid,
  output logic              tick_stall,
  input  logic              tick,
  output logic              valid,
  input  logic              down_ready,
  output logic [FRAC_W-1:0] frac
);

  logic [PHASE_BITS-1:0]        phase;
  logic [SUM_W-1:0]             phase_sum;
  logic [PHASE_BITS-1:0]        phase_next;
  logic [PHASE_BITS+FRAC_W-1:0] phase_wide;
  logic                         ready;
  logic                         acc;

  // Stage takes a word when empty or draining
  assign ready      = !valid || down_ready;
  assign tick_stall = !ready;
  assign acc        = tick_valid && ready;

  // Wrapping add, then the top FRAC_W bits as the cycle fraction
  assign phase_sum  = SUM_W'(phase) + SUM_W'(cfg.phase_step);
  assign phase_next = phase_sum[PHASE_BITS-1:0];
  assign phase_wide = {phase_next, {FRAC_W{1'b0}}};

  // Advance phase only on a tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      valid <= 1'b0;
    end else begin
      if (acc && tick) begin
        phase <= phase_next;
      end
      if (ready) begin
        valid <= acc && tick;
      end
    end
  end

  // Fraction register, payload only
  always_ff @(posedge clk) begin
    if (ready) begin
      frac <= phase_wide[PHASE_BITS+FRAC_W-1 -: FRAC_W];
    end
  end

  `WNG_ASSERT_NEXT(a_phase_advance, !rst && acc && tick, phase == $past(phase_next),
                   "phase did not advance by the step on a tick")
  `WNG_ASSERT_NEXT(a_phase_hold, !rst && !(acc && tick), $stable(phase),
                   "phase moved without a tick")
  `WNG_ASSERT(a_stage_hold, (!rst && valid && !down_ready) |=> (valid && $stable(frac)),
              "stalled phase stage lost its word")

endmodule

`default_nettype wire

// ===== rtl/wng_wave.sv =====
// ----------------------------------------------------------------------------
// wng_wave
// Wave shaping: sine table read and square, triangle, sawtooth from phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wng_wave import wng_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  logic [FRAC_W-1:0]        frac,
  output logic                     valid,
  input  logic                     down_ready,
  output logic signed [WAVE_W-1:0] wave
);

  logic [1:0]                  quad;
  logic [SINE_TABLE_BITS-1:0]  idx;
  logic [ROM_ADDR_W-1:0]       rom_addr;
  logic signed [WAVE_W+1:0]    tri_base;
  logic signed [WAVE_W+1:0]    tri_val;
  logic signed [WAVE_W-1:0]    shape_next;

  // Table stage registers
  logic                        tab_valid;
  logic [SINE_W-1:0]           rom_q;
  logic                        sine_neg;
  logic                        is_sine;
  logic signed [WAVE_W-1:0]    shape;
  logic                        tab_ready;

  logic signed [WAVE_W-1:0]    sine_val;

  assign tab_ready = !tab_valid || !valid || down_ready;
  assign up_ready  = tab_ready;

  // Quarter-wave folding
  assign quad     = frac[FRAC_W-1 -: 2];
  assign idx      = frac[FRAC_W-3 -: SINE_TABLE_BITS];
  assign rom_addr = quad[0] ? (ROM_ADDR_W'(TAB_N) - {1'b0, idx}) : {1'b0, idx};

  // Triangle from the top 17 fraction bits
  assign tri_base = (WAVE_W+2)'({2'b00, frac[FRAC_W-1 -: WAVE_W]});
  always_comb begin
    case (quad)
      2'd0:    tri_val = tri_base;
      2'd3:    tri_val = tri_base - (WAVE_W+2)'(131072);
      default: tri_val = (WAVE_W+2)'(65536) - tri_base;
    endcase
  end

  // Non-sine shapes
  always_comb begin
    case (cfg.wave_type)
      WAVE_SQUARE:   shape_next = (frac != '0 && !frac[FRAC_W-1]) ? WAVE_POS_ONE
                                                                  : WAVE_NEG_ONE;
      WAVE_TRIANGLE: shape_next = tri_val[WAVE_W-1:0];
      WAVE_SAWTOOTH: shape_next = WAVE_W'($signed(frac[FRAC_W-1 -: 16]));
      default:       shape_next = '0;
    endcase
  end

  // Table read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      tab_valid <= 1'b0;
    end else if (tab_ready) begin
      tab_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_ready) begin
      rom_q    <= SINE_ROM[rom_addr];
      sine_neg <= quad[1];
      is_sine  <= (cfg.wave_type == WAVE_SINE);
      shape    <= shape_next;
    end
  end

  // Sign the table value and pick the wave
  assign sine_val = sine_neg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!valid || down_ready) begin
      valid <= tab_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!valid || down_ready) begin
      wave <= is_sine ? sine_val : shape;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wng_scale.sv =====
// ----------------------------------------------------------------------------
// wng_scale
// Amplitude multiply with floor shift, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wng_scale import wng_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic signed [WAVE_W-1:0]   wave,
  output logic                       sample_valid,
  input  logic                       sample_stall,
  output logic signed [SAMPLE_W-1:0] sample
);

  logic signed [PROD_W-1:0] prod;

  assign up_ready = !sample_valid || !sample_stall;

  // Signed product; arithmetic shift rounds toward minus infinity
  assign prod = PROD_W'($signed({1'b0, cfg.amplitude})) * PROD_W'(wave);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (up_ready) begin
      sample_valid <= up_valid;
    end
  end

  // Hold the word while stalled
  always_ff @(posedge clk) begin
    if (up_ready) begin
      sample <= prod[SCALE_SHIFT+SAMPLE_W-1:SCALE_SHIFT];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/waveform_nco_generator.sv =====
// Numerically controlled oscillator. Every accepted word with tick high adds
// phase_step to a 32-bit wrapping phase accumulator and yields one sample of the
// selected wave (sine from a 1025-entry quarter-wave ROM, square, triangle or
// sawtooth) scaled by amplitude in u4.12; a word with tick low yields nothing.
// One word is taken per clock while tick_stall is low. Each sample passes
// through four registers loaded in turn: phase add (at the edge that takes its
// word), ROM read, wave select, amplitude multiply. The 32-bit phase add is the
// only loop and sets the clock limit together with the multiply stage.
// cfg_ready is always high; write registers only while the pipe is empty.
// ----------------------------------------------------------------------------
// waveform_nco_generator
// Top level: configuration registers, phase, wave shaping and scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module waveform_nco_generator import wng_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       tick_valid,
  output logic                       tick_stall,
  input  logic                       tick,
  output logic                       sample_valid,
  input  logic                       sample_stall,
  output logic signed [SAMPLE_W-1:0] sample
);

  cfg_t                     cfg;
  logic                     ph_valid;
  logic                     ph_ready;
  logic [FRAC_W-1:0]        ph_frac;
  logic                     wv_valid;
  logic                     wv_ready;
  logic signed [WAVE_W-1:0] wv_wave;

  // Registers
  wng_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Phase accumulator
  wng_phase u_phase (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .tick       (tick),
    .valid      (ph_valid),
    .down_ready (ph_ready),
    .frac       (ph_frac)
  );

  // Wave shaping
  wng_wave u_wave (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (ph_valid),
    .up_ready   (ph_ready),
    .frac       (ph_frac),
    .valid      (wv_valid),
    .down_ready (wv_ready),
    .wave       (wv_wave)
  );

  // Gain and output register
  wng_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .up_valid     (wv_valid),
    .up_ready     (wv_ready),
    .wave         (wv_wave),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample)
  );

endmodule

`default_nettype wire

// ===== tb/tb_nco_checker.sv =====
// ----------------------------------------------------------------------------
// tb_nco_checker
// Watches the config, tick and sample channels of the NCO. Keeps its own copy
// of the registers and the phase accumulator, works out each sample when its
// tick word is taken, and compares every sample word with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nco_checker import wng_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       tick_valid,
  input  logic                       tick_stall,
  input  logic                       tick,
  input  logic                       sample_valid,
  input  logic                       sample_stall,
  input  logic signed [SAMPLE_W-1:0] sample,
  output int                         outstanding,
  output int                         fail_count,
  output int                         sample_count
);

  // Quarter-wave sine, TAB_N + 1 entries in s1.15
  int                  quarter_wave [0:TAB_N];

  // Shadow registers and phase
  wave_t               shape;
  logic [STEP_W-1:0]   step;
  logic [AMP_W-1:0]    gain;
  logic [31:0]         acc;

  logic [SAMPLE_W-1:0] due_samples [$];
  int                  errors;
  int                  seen;

  // Build the table: Taylor series in Q30, rounded to Q15
  initial begin : build_quarter_wave
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    for (int i = 0; i < TAB_N; i++) begin
      x    = (longint'(i) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2) >> 30;
        term = term / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      quarter_wave[i] = int'((sum + 64'd16384) >> 15);
    end
    quarter_wave[TAB_N] = 32768;
  end

  // Wave value in s1.15 at phase fraction f
  function automatic int wave_at(input wave_t w, input logic [31:0] f);
    int idx;
    int v;
    idx = int'(f[29 -: SINE_TABLE_BITS]);
    case (w)
      WAVE_SINE: begin
        case (f[31:30])
          2'd0:    v = quarter_wave[idx];
          2'd1:    v = quarter_wave[TAB_N - idx];
          2'd2:    v = -quarter_wave[idx];
          default: v = -quarter_wave[TAB_N - idx];
        endcase
      end
      WAVE_SQUARE: begin
        v = (f != 32'd0 && f < 32'h8000_0000) ? 32768 : -32768;
      end
      WAVE_TRIANGLE: begin
        if (f < 32'h4000_0000) v = int'(f >> 15);
        else if (f < 32'hC000_0000) v = 65536 - int'(f >> 15);
        else v = int'(f >> 15) - 131072;
      end
      default: begin
        if (f < 32'h8000_0000) v = int'(f >> 16);
        else v = int'(f >> 16) - 65536;
      end
    endcase
    return v;
  endfunction

  // Scale by the u4.12 gain, flooring shift
  function automatic logic [SAMPLE_W-1:0] scaled_sample(input logic [31:0] f);
    longint prod;
    longint scaled;
    prod   = longint'({48'd0, gain}) * longint'(wave_at(shape, f));
    scaled = prod >>> SCALE_SHIFT;
    return scaled[SAMPLE_W-1:0];
  endfunction

  // Track registers, predict on each tick word, compare on each sample word
  always @(posedge clk) begin : watch
    logic [SAMPLE_W-1:0] want;
    if (rst) begin
      shape  = WAVE_SINE;
      step   = '0;
      gain   = AMP_RESET;
      acc    = '0;
      errors = 0;
      seen   = 0;
      due_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WAVE_TYPE:  shape = wave_t'(cfg_data[1:0]);
          REG_PHASE_STEP: step  = cfg_data[STEP_W-1:0];
          REG_AMPLITUDE:  gain  = cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      if (tick_valid && !tick_stall && tick) begin
        acc = acc + step;
        due_samples.push_back(scaled_sample(acc));
      end
      if (sample_valid && !sample_stall) begin
        seen++;
        if (due_samples.size() == 0) begin
          $display("%0t: sample word with none due: expected none, actual %0d",
                   $time, sample);
          errors++;
        end else begin
          want = due_samples.pop_front();
          if (sample !== want) begin
            $display("%0t: sample mismatch: expected %0d, actual %0d",
                     $time, $signed(want), sample);
            errors++;
          end
        end
      end
    end
    outstanding  <= due_samples.size();
    fail_count   <= errors;
    sample_count <= seen;
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the NCO. Drives register writes between phases,
// tick words with random gaps and sample-side stalls, one long output hold,
// and a directed sweep of every wave at its corner phases and gains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import wng_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 500000;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;
  logic                       tick_valid;
  logic                       tick_stall;
  logic                       tick;
  logic                       sample_valid;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample;

  int outstanding;
  int fail_count;
  int sample_count;
  int cycle_count = 0;
  int settings    = 0;
  int quiet_words = 0;

  bit sender_idle;
  bit sink_idle;
  bit hold_req;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  waveform_nco_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample)
  );

  tb_nco_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .outstanding  (outstanding),
    .fail_count   (fail_count),
    .sample_count (sample_count)
  );

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Sample side: random stall bursts, and one long hold on request
  initial begin : sample_sink
    bit held;
    held         = 1'b0;
    sample_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        sample_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sample_stall <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        sample_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        sample_stall <= 1'b0;
      end
    end
  end

  // Offer one tick word and hold it until taken; valid stays high
  task automatic send_word(input logic t);
    tick_valid <= 1'b1;
    tick       <= t;
    if (!t) quiet_words++;
    do @(posedge clk); while (tick_stall);
  endtask

  task automatic tick_burst(input int n);
    repeat (n) send_word(1'b1);
  endtask

  // Drop valid, drain all due samples, then let the pipe empty
  task automatic settle();
    tick_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random register setting; the first two phases take the extremes
  task automatic pick_setting(input int p);
    logic [STEP_W-1:0] stp;
    logic [AMP_W-1:0]  amp;
    case ($urandom_range(0, 5))
      0:       stp = $urandom;
      1:       stp = $urandom_range(1, 1 << 20);
      2:       stp = '1;
      3:       stp = 32'h8000_0000 >> $urandom_range(0, 12);
      4:       stp = '0;
      default: stp = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
    endcase
    case ($urandom_range(0, 3))
      0:       amp = '0;
      1:       amp = '1;
      2:       amp = AMP_RESET;
      default: amp = $urandom_range(0, 65535);
    endcase
    if (p == 0) begin
      stp = '1;
      amp = '1;
    end else if (p == 1) begin
      stp = '0;
      amp = '0;
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom);
    write_reg(REG_WAVE_TYPE, $urandom);
    write_reg(REG_PHASE_STEP, stp);
    write_reg(REG_AMPLITUDE, {16'($urandom), amp});
    settings++;
  endtask

  // Send words until n of them carry tick high
  task automatic run_stream(input int n);
    int   sent;
    logic t;
    sent = 0;
    while (sent < n) begin
      if (sender_idle && $urandom_range(0, 3) == 0) begin
        tick_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      t = ($urandom_range(0, 6) != 0);
      send_word(t);
      if (t) sent++;
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tick_valid  = 1'b0;
    tick        = 1'b0;
    sender_idle = 1'b0;
    sink_idle   = 1'b1;
    hold_req    = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values: sine, zero step, unit gain
    tick_burst(2);
    // Unknown index leaves everything alone
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    tick_burst(1);
    // Square on quarter steps: half and zero both give minus one;
    // upper data bits are dropped
    write_reg(REG_WAVE_TYPE, 32'hFFFF_FFFD);
    write_reg(REG_PHASE_STEP, 32'h4000_0000);
    write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
    send_word(1'b0);
    tick_burst(4);
    write_reg(REG_WAVE_TYPE, 32'(WAVE_TRIANGLE));
    write_reg(REG_AMPLITUDE, 32'(AMP_RESET));
    tick_burst(4);
    write_reg(REG_WAVE_TYPE, 32'(WAVE_SAWTOOTH));
    tick_burst(4);
    // Sine stepping backward across the zero-phase edge, then one entry a tick
    write_reg(REG_WAVE_TYPE, 32'(WAVE_SINE));
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_AMPLITUDE, 32'h0000_FFFF);
    tick_burst(4);
    write_reg(REG_PHASE_STEP, 32'h0010_0000);
    tick_burst(3);
    write_reg(REG_AMPLITUDE, 32'h0);
    tick_burst(2);
    settings += 6;

    // Random phases, with some stretches of no idling on each side
    for (int p = 0; p < 11; p++) begin
      sender_idle = (p % 4 != 3);
      sink_idle <= (p % 4 != 2);
      pick_setting(p);
      run_stream(128);
    end

    // Long output hold while ticks keep coming
    pick_setting(11);
    sender_idle = 1'b0;
    hold_req <= 1'b1;
    run_stream(80);
    hold_req <= 1'b0;

    // Tail at full rate
    sink_idle <= 1'b0;
    pick_setting(12);
    run_stream(200);
    settle();

    $display("tb_top: %0d samples checked across %0d register settings,", sample_count,
             settings);
    $display("tb_top: %0d tick-low words, all four waves, one long output hold",
             quiet_words);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
